### rtl/core/lmd_pkg.sv
// Shared types, constants and elaboration-time tables for the low-IF mixer and decimator.
// No dependencies.
`default_nettype none
package lmd_pkg;

    localparam int TAPS_PER_FACTOR = 16;
    localparam int MAX_TAPS        = 65;
    localparam int COEF_WIDTH      = 18;
    localparam int SINE_TABLE_BITS = 10;
    localparam int SIN_DEPTH       = 1 << SINE_TABLE_BITS;
    localparam int HIST_W          = 18;
    localparam int TAP_W           = $clog2(MAX_TAPS);

    localparam logic [31:0] STEP_M1 = 32'd1159641170;
    localparam logic [31:0] STEP_M2 = 32'd1099511628;

    localparam logic [1:0] MODE_BYPASS = 2'd0;
    localparam logic [1:0] MODE_6M     = 2'd1;
    localparam logic [1:0] MODE_8M     = 2'd2;

    localparam longint unsigned Q30_ONE   = 64'd1073741824;
    localparam longint unsigned HALF_PI   = 64'd1686629713;
    localparam longint          TWO_PI_R  = 64'sd683565276;
    localparam longint          HAM_A     = 64'sd579820585;
    localparam longint          HAM_B     = 64'sd493921239;

    typedef struct packed {
        logic signed [HIST_W-1:0] q;
        logic signed [HIST_W-1:0] i;
    } t_iq;

    typedef struct packed {
        logic clr;
        logic shift;
        logic rot;
    } t_cell_ctl;

    typedef logic signed [COEF_WIDTH-1:0] t_coef_tab [MAX_TAPS];
    typedef logic signed [17:0] t_sin_rom [SIN_DEPTH];

    function automatic longint unsigned mag64(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // unsigned long division by shift and subtract, table building only
    function automatic longint unsigned udiv(input longint unsigned n,
                                             input longint unsigned d);
        longint unsigned q, r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint mul_q30(input longint a, input longint b);
        longint unsigned m;
        m = (mag64(a) * mag64(b) + (64'd1 << 29)) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    // sin(2*pi*turn/2^32) in Q30, Taylor series on the folded quadrant
    function automatic longint sin_q30(input logic [31:0] turn);
        longint unsigned r, x, x2, t;
        r = {34'd0, turn[29:0]};
        if (turn[30]) r = Q30_ONE - r;
        x  = (r * HALF_PI) >> 30;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        x  = (x * t) >> 30;
        return turn[31] ? -longint'(x) : longint'(x);
    endfunction

    function automatic t_sin_rom build_sin();
        t_sin_rom rom;
        longint v;
        longint unsigned m;
        for (int k = 0; k < SIN_DEPTH; k++) begin
            v = sin_q30(32'(k) << (32 - SINE_TABLE_BITS));
            m = (mag64(v) + (64'd1 << 12)) >> 13;
            v = (v < 0) ? -longint'(m) : longint'(m);
            if (v > 131071) v = 131071;
            if (v < -131072) v = -131072;
            rom[k] = 18'(v);
        end
        return rom;
    endfunction

    function automatic t_coef_tab build_coefs(input int factor);
        t_coef_tab tab;
        longint h [MAX_TAPS];
        longint sum, sinc, win, s, c, m2, cmax;
        longint unsigned am, d, den, m;
        logic [31:0] turn, wt;
        int t;
        sum  = 0;
        cmax = (64'sd1 <<< (COEF_WIDTH - 1)) - 1;
        t    = TAPS_PER_FACTOR * factor + 1;
        if (t > MAX_TAPS) t = MAX_TAPS;
        den  = (t > 1) ? longint'(t - 1) : 1;
        for (int n = 0; n < MAX_TAPS; n++) begin
            h[n]   = 0;
            tab[n] = '0;
        end
        for (int n = 0; n < t; n++) begin
            m2 = 2 * longint'(n) - longint'(t - 1);
            am = mag64(m2);
            if (am == 0) begin
                sinc = longint'(udiv(9 * Q30_ONE + 5 * longint'(factor),
                                     10 * longint'(factor)));
            end else begin
                d    = 200 * longint'(factor);
                turn = 32'(udiv(((45 * am) << 32) + d / 2, d));
                s    = mul_q30(sin_q30(turn), TWO_PI_R);
                m    = udiv(mag64(s) + am / 2, am);
                sinc = (s < 0) ? -longint'(m) : longint'(m);
            end
            wt   = 32'(udiv(longint'(n) << 32, den));
            c    = sin_q30(wt + 32'h4000_0000);
            win  = HAM_A - mul_q30(HAM_B, c);
            h[n] = mul_q30(sinc, win);
            sum  = sum + h[n];
        end
        for (int n = 0; n < t; n++) begin
            s = h[n] * (64'sd1 <<< (COEF_WIDTH - 1));
            m = udiv(mag64(s) + longint'(sum) / 2, longint'(sum));
            c = (s < 0) ? -longint'(m) : longint'(m);
            if (c > cmax) c = cmax;
            if (c < -cmax - 1) c = -cmax - 1;
            tab[n] = COEF_WIDTH'(c);
        end
        return tab;
    endfunction

    localparam t_sin_rom  SIN_ROM = build_sin();
    localparam t_coef_tab COEF_M1 = build_coefs(3);
    localparam t_coef_tab COEF_M2 = build_coefs(4);
    localparam int TAPS_M1 = (TAPS_PER_FACTOR * 3 + 1 > MAX_TAPS) ? MAX_TAPS : TAPS_PER_FACTOR * 3 + 1;
    localparam int TAPS_M2 = (TAPS_PER_FACTOR * 4 + 1 > MAX_TAPS) ? MAX_TAPS : TAPS_PER_FACTOR * 4 + 1;

endpackage
`default_nettype wire

### rtl/core/lmd_cell.sv
// One delay-line cell: holds one mixed I/Q sample, shifts in from the left or rotates from the right.
// Depends on lmd_pkg.
`default_nettype none
module lmd_cell (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire lmd_pkg::t_cell_ctl i_ctl,
    input  wire logic             i_wrap,
    input  wire lmd_pkg::t_iq     i_left,
    input  wire lmd_pkg::t_iq     i_right,
    input  wire lmd_pkg::t_iq     i_ring,
    output lmd_pkg::t_iq          o_val
);
    import lmd_pkg::*;

    t_iq r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_val <= '0;
        end else if (i_ctl.shift) begin
            r_val <= i_left;
        end else if (i_ctl.rot) begin
            r_val <= i_wrap ? i_ring : i_right;
        end
    end

    assign o_val = r_val;
endmodule
`default_nettype wire

### rtl/core/lmd_mixer.sv
// Phase accumulator, registered sine ROM and complex mixer, two register stages.
// Depends on lmd_pkg.
`default_nettype none
module lmd_mixer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_clr,
    input  wire logic               i_adv,
    input  wire logic               i_sel8,
    input  wire logic signed [15:0] i_xi,
    input  wire logic signed [15:0] i_xq,
    output lmd_pkg::t_iq            o_mixed
);
    import lmd_pkg::*;

    logic [31:0]              r_phase;
    logic signed [17:0]       r_s, r_c;
    logic signed [15:0]       r_xi, r_xq;
    logic signed [33:0]       r_ic, r_qs, r_qc, r_is;
    logic [SINE_TABLE_BITS-1:0] k_s, k_c;

    assign k_s = r_phase[31 -: SINE_TABLE_BITS];
    assign k_c = k_s + SINE_TABLE_BITS'(SIN_DEPTH / 4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_phase <= '0;
        end else if (i_adv) begin
            r_phase <= r_phase + (i_sel8 ? STEP_M2 : STEP_M1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s  <= SIN_ROM[k_s];
            r_c  <= SIN_ROM[k_c];
            r_xi <= i_xi;
            r_xq <= i_xq;
        end
        r_ic <= 34'(r_xi) * 34'(r_c);
        r_qs <= 34'(r_xq) * 34'(r_s);
        r_qc <= 34'(r_xq) * 34'(r_c);
        r_is <= 34'(r_xi) * 34'(r_s);
    end

    function automatic logic signed [HIST_W-1:0] rnd17(input logic signed [34:0] v);
        logic [34:0] m;
        logic [17:0] r;
        m = v[34] ? 35'(-v) : v;
        r = 18'((m + 35'd65536) >> 17);
        return v[34] ? -r : r;
    endfunction

    assign o_mixed.i = rnd17(35'(r_ic) + 35'(r_qs));
    assign o_mixed.q = rnd17(35'(r_qc) - 35'(r_is));

`ifndef SYNTHESIS
    a_clr_phase: assert property (@(posedge i_clk) i_rst_n && i_clr |=> r_phase == '0)
        else $error("phase not cleared");
    a_hold_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv && !i_clr |=> $stable(r_phase))
        else $error("phase moved without an input");
    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_adv && i_clr))
        else $error("advance during clear");
`endif
endmodule
`default_nettype wire

### rtl/core/low_if_mix_decimate.sv
// Top level: low-IF complex mixer and decimating FIR with a rotating chain of delay cells.
// Depends on lmd_pkg, lmd_mixer and lmd_cell.
//
// Input words (i_s_*) carry one complex sample, output words (o_m_*) one filtered sample.
// A word moves when tvalid and tready are both high at a rising edge of i_clk.
// The mode register is written over i_cfg_valid/o_cfg_ready/i_cfg_data while idle;
// a write clears the delay line, oscillator and decimation phase.
// Bypass (mode 0 or 3): each input is copied to the output register, one word
// per cycle when the receiver keeps up.
// Filter modes: an input passes through ROM read, product, and sum and shift into
// the chain. Every third or fourth input then runs the MAC: the ring of cells
// turns once past one shared pair of multipliers, one tap a cycle, then the
// last product is added and the word waits for the output register. No new
// input is taken until the MAC has written its word.
// Reset (i_rst_n low, synchronous) selects bypass and clears the control state,
// delay line and oscillator phase. If the receiver stalls, a finished word waits
// in the output register; in the filter modes the next input is still taken, and
// the MAC holds before its final write until the register is free.
`default_nettype none
module low_if_mix_decimate (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_data,   // mode
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,    // [15:0] i_in, [31:16] q_in
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata     // [15:0] i_out, [31:16] q_out
);
    import lmd_pkg::*;

    localparam int ACC_W = 2 * HIST_W + TAP_W + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SUM, S_MAC, S_LAST, S_OUT
    } t_state;

    t_state             r_state;
    logic [1:0]         r_mode;
    logic [1:0]         r_dphase;
    logic [TAP_W-1:0]   r_cnt;
    logic               r_pv;
    logic signed [2*HIST_W-1:0] r_pi, r_pq;
    logic signed [ACC_W-1:0]    r_acc_i, r_acc_q;
    logic [15:0]        r_out_i, r_out_q;
    logic               r_out_v;

    logic       filt, sel8, cfg_acc, in_acc, out_free, out_load;
    logic [1:0] last_ph;
    logic [TAP_W-1:0] taps_m1;
    t_cell_ctl  ctl;
    t_iq        mixed;
    t_iq        cell_q [MAX_TAPS];
    logic signed [COEF_WIDTH-1:0] coef;

    assign filt     = (r_mode == MODE_6M) || (r_mode == MODE_8M);
    assign sel8     = (r_mode == MODE_8M);
    assign last_ph  = sel8 ? 2'd3 : 2'd2;
    assign taps_m1  = sel8 ? TAP_W'(TAPS_M2 - 1) : TAP_W'(TAPS_M1 - 1);
    assign out_free = !r_out_v || i_m_tready;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_s_tready  = (r_state == S_IDLE) && !i_cfg_valid && (filt || out_free);
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign in_acc      = i_s_tvalid && o_s_tready;

    // output register loads a bypass word or a finished MAC result
    assign out_load = (in_acc && !filt) || ((r_state == S_OUT) && out_free);

    assign ctl.clr   = cfg_acc;
    assign ctl.shift = (r_state == S_SUM);
    assign ctl.rot   = (r_state == S_MAC);

    lmd_mixer u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (cfg_acc),
        .i_adv   (in_acc && filt),
        .i_sel8  (sel8),
        .i_xi    (i_s_tdata[15:0]),
        .i_xq    (i_s_tdata[31:16]),
        .o_mixed (mixed)
    );

    // Delay line: cell 0 holds the newest sample; during the MAC the ring
    // turns towards cell 0 and the end cell takes cell 0 back.
    for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
        lmd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_wrap  (TAP_W'(j) == taps_m1),
            .i_left  ((j == 0) ? mixed : cell_q[(j == 0) ? 0 : j - 1]),
            .i_right (cell_q[(j == MAX_TAPS - 1) ? j : j + 1]),
            .i_ring  (cell_q[0]),
            .o_val   (cell_q[j])
        );
    end

    assign coef = sel8 ? COEF_M2[r_cnt] : COEF_M1[r_cnt];

    // round half away from zero by COEF_WIDTH-1 bits, saturate to 16 bits
    function automatic logic [15:0] rnd_sat(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] m, r;
        m = v[ACC_W-1] ? ACC_W'(-v) : v;
        r = (m + (ACC_W'(1) << (COEF_WIDTH - 2))) >> (COEF_WIDTH - 1);
        if (!v[ACC_W-1]) begin
            return (r > ACC_W'(32767)) ? 16'h7FFF : r[15:0];
        end else begin
            return (r > ACC_W'(32768)) ? 16'h8000 : 16'(-r);
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= MODE_BYPASS;
            r_dphase <= '0;
            r_out_v  <= 1'b0;
            r_pv     <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (cfg_acc) begin
                        r_mode   <= i_cfg_data;
                        r_dphase <= '0;
                    end else if (in_acc) begin
                        if (filt) begin
                            r_state <= S_MUL;
                        end else begin
                            r_out_i <= i_s_tdata[15:0];
                            r_out_q <= i_s_tdata[31:16];
                        end
                    end
                end
                S_MUL: r_state <= S_SUM;
                S_SUM: begin
                    r_dphase <= (r_dphase == last_ph) ? 2'd0 : r_dphase + 2'd1;
                    if (r_dphase == 2'd0) begin
                        r_state <= S_MAC;
                        r_cnt   <= '0;
                        r_pv    <= 1'b0;
                        r_acc_i <= '0;
                        r_acc_q <= '0;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_MAC: begin
                    r_pi <= cell_q[0].i * coef;
                    r_pq <= cell_q[0].q * coef;
                    r_pv <= 1'b1;
                    if (r_pv) begin
                        r_acc_i <= r_acc_i + ACC_W'(r_pi);
                        r_acc_q <= r_acc_q + ACC_W'(r_pq);
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == taps_m1) r_state <= S_LAST;
                end
                S_LAST: begin
                    r_acc_i <= r_acc_i + ACC_W'(r_pi);
                    r_acc_q <= r_acc_q + ACC_W'(r_pq);
                    r_pv    <= 1'b0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_i <= rnd_sat(r_acc_i);
                        r_out_q <= rnd_sat(r_acc_q);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {r_out_q, r_out_i};

`ifndef SYNTHESIS
    a_busy_no_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_s_tready && !o_cfg_ready)
        else $error("input taken while busy");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MAC |-> r_cnt <= taps_m1)
        else $error("tap counter overran");
    a_mac_after_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MAC && r_cnt == '0 |-> $past(r_state) == S_SUM)
        else $error("MAC started out of sequence");
    a_out_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && !out_free |=> r_state == S_OUT)
        else $error("result dropped");
`endif
endmodule
`default_nettype wire

### verif/tb_low_if_mix_decimate.sv
// Self-checking testbench for low_if_mix_decimate: directed table, then random complex samples
// across all modes, checked against an in-bench mixer/FIR predictor. Depends on lmd_pkg.
`default_nettype none
module tb_low_if_mix_decimate;
    timeunit 1ns;
    timeprecision 1ps;
    import lmd_pkg::*;

    localparam longint unsigned ONE_Q30 = 64'd1073741824;
    localparam int LIMIT = 3_000_000;

    typedef struct {
        logic [15:0] i;
        logic [15:0] q;
    } t_iq_word;

    typedef struct {
        int          wr_mode;  // mode written before the row, -1 for none
        logic [15:0] i;
        logic [15:0] q;
        bit          typed;    // expected value given in the row
        logic [15:0] ei;
        logic [15:0] eq;
    } t_row;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_data = MODE_BYPASS;
    logic        s_valid = 1'b0;
    logic [31:0] s_data = '0;
    logic        m_ready = 1'b0;
    wire         cfg_ready, s_ready, m_valid;
    wire  [31:0] m_data;

    low_if_mix_decimate i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_s_tvalid(s_valid), .o_s_tready(s_ready), .i_s_tdata(s_data),
        .o_m_tvalid(m_valid), .i_m_tready(m_ready), .o_m_tdata(m_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---- predictor state and tables ----
    longint      osc_sin [1024];
    longint      fir_coef [2][65];
    int          fir_taps [2];
    logic [1:0]  mode_r;
    longint      line_i [65];
    longint      line_q [65];
    int          wr_pos, dec_ph;
    logic [31:0] nco;

    t_iq_word    pending[$];
    int          errors = 0;
    int          cycles = 0;
    bit          use_typed = 1'b0;
    t_iq_word    typed_word;
    bit          idle_en = 1'b1;

    function automatic longint sgn(input longint unsigned m, input bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned absv(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint rnd_shr(input longint v, input int sh);
        return sgn((absv(v) + (64'd1 << (sh - 1))) >> sh, v < 0);
    endfunction

    function automatic longint rnd_div(input longint num, input longint den);
        longint unsigned d;
        d = (den > 0) ? den : 1;
        return sgn((absv(num) + d / 2) / d, num < 0);
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return sgn((absv(a) * absv(b) + (64'd1 << 29)) >> 30, (a < 0) != (b < 0));
    endfunction

    // sine of a 32-bit turn in Q30 (folded quadrant, Taylor series)
    function automatic longint sine_turn(input logic [31:0] turn);
        longint unsigned r, x, x2, t;
        r = turn[29:0];
        if (turn[30]) r = ONE_Q30 - r;
        x  = (r * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
        return sgn((x * t) >> 30, turn[31]);
    endfunction

    task automatic make_tables();
        longint h [65];
        longint v, acc, sinc, win, c;
        longint unsigned am, d;
        logic [31:0] turn;
        int t, f;
        for (int k = 0; k < 1024; k++) begin
            v = rnd_shr(sine_turn(32'(k) << 22), 13);
            if (v > 131071) v = 131071;
            if (v < -131072) v = -131072;
            osc_sin[k] = v;
        end
        for (int sel = 0; sel < 2; sel++) begin
            f = sel + 3;
            t = 16 * f + 1;
            if (t > 65) t = 65;
            fir_taps[sel] = t;
            acc = 0;
            for (int n = 0; n < t; n++) begin
                am = absv(2 * n - (t - 1));
                if (am == 0) begin
                    sinc = (9 * ONE_Q30 + 5 * f) / (10 * f);
                end else begin
                    d    = 200 * f;
                    turn = 32'((((45 * am) << 32) + d / 2) / d);
                    sinc = rnd_div(qmul(sine_turn(turn), 64'sd683565276), am);
                end
                turn = 32'((longint'(n) << 32) / (t - 1));
                win  = 64'sd579820585 - qmul(64'sd493921239, sine_turn(turn + 32'h4000_0000));
                h[n] = qmul(sinc, win);
                acc += h[n];
            end
            for (int n = 0; n < t; n++) begin
                c = rnd_div(h[n] * (64'sd1 <<< 17), acc);
                if (c > 131071) c = 131071;
                if (c < -131072) c = -131072;
                fir_coef[sel][n] = c;
            end
        end
    endtask

    function automatic void clear_line();
        for (int n = 0; n < 65; n++) begin
            line_i[n] = 0;
            line_q[n] = 0;
        end
        wr_pos = 0;
        dec_ph = 0;
        nco    = '0;
    endfunction

    // in bypass pass the word through; else mix, shift into the line, and on the decimation phase run the FIR
    function automatic bit mix_filter(input logic [15:0] ii, input logic [15:0] qq,
                                      output t_iq_word res);
        longint xi, xq, sn, cs, ai, aq;
        int sel, fac, taps, k, idx;
        xi = longint'($signed(ii));
        xq = longint'($signed(qq));
        if (mode_r != MODE_6M && mode_r != MODE_8M) begin
            res.i = ii;
            res.q = qq;
            return 1'b1;
        end
        sel  = (mode_r == MODE_6M) ? 0 : 1;
        fac  = sel + 3;
        taps = fir_taps[sel];
        k    = nco[31:22];
        sn   = osc_sin[k];
        cs   = osc_sin[(k + 256) % 1024];
        nco += (mode_r == MODE_6M) ? STEP_M1 : STEP_M2;
        if (wr_pos >= taps) wr_pos = 0;
        line_i[wr_pos] = rnd_shr(xi * cs + xq * sn, 17);
        line_q[wr_pos] = rnd_shr(xq * cs - xi * sn, 17);
        wr_pos = (wr_pos + 1) % taps;
        if (dec_ph >= fac) dec_ph = 0;
        if (dec_ph != 0) begin
            dec_ph = (dec_ph + 1) % fac;
            return 1'b0;
        end
        ai = 0;
        aq = 0;
        for (int tp = 0; tp < taps; tp++) begin
            idx = (wr_pos + taps - 1 - tp) % taps;
            ai += fir_coef[sel][tp] * line_i[idx];
            aq += fir_coef[sel][tp] * line_q[idx];
        end
        ai = rnd_shr(ai, 17);
        aq = rnd_shr(aq, 17);
        res.i = (ai > 32767) ? 16'h7fff : (ai < -32768) ? 16'h8000 : 16'(ai);
        res.q = (aq > 32767) ? 16'h7fff : (aq < -32768) ? 16'h8000 : 16'(aq);
        dec_ph = (dec_ph + 1) % fac;
        return 1'b1;
    endfunction

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] exp);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, exp, $realtime);
        errors++;
    endtask

    // ---- monitor: sampled at the rising edge, before the block's own updates ----
    always @(posedge clk) begin
        t_iq_word w, e;
        cycles++;
        if (!rst_n) begin
            mode_r = MODE_BYPASS;
            clear_line();
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_r = cfg_data;
                clear_line();
            end
            if (s_valid && s_ready) begin
                if (mix_filter(s_data[15:0], s_data[31:16], w))
                    pending.push_back(use_typed ? typed_word : w);
            end
            if (m_valid && m_ready) begin
                if (pending.size() == 0) begin
                    report("unexpected word, i_out", m_data[15:0], 16'h0000);
                end else begin
                    e = pending.pop_front();
                    if (m_data[15:0] !== e.i) report("i_out", m_data[15:0], e.i);
                    if (m_data[31:16] !== e.q) report("q_out", m_data[31:16], e.q);
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---- receiver: bursts of ready with occasional long stalls ----
    initial begin
        int n;
        forever begin
            n = $urandom_range(1, 30);
            repeat (n) @(negedge clk) m_ready <= 1'b1;
            n = idle_en ? (($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                       : $urandom_range(0, 3)) : 0;
            repeat (n) @(negedge clk) m_ready <= 1'b0;
        end
    end

    function automatic int pick_gap();
        int r;
        if (!idle_en) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // the expected word for a typed row is set with the data, at the falling edge
    task automatic send_word(input logic [15:0] ii, input logic [15:0] qq, input bit typed,
                             input logic [15:0] ei, input logic [15:0] eq);
        repeat (pick_gap()) @(negedge clk) s_valid <= 1'b0;
        @(negedge clk);
        s_valid      <= 1'b1;
        s_data       <= {qq, ii};
        use_typed    = typed;
        typed_word.i = ei;
        typed_word.q = eq;
        do @(posedge clk); while (!(s_valid && s_ready));
    endtask

    // drain, let the block settle, then write the mode register
    task automatic write_mode(input logic [1:0] m);
        @(negedge clk) s_valid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 63)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    t_row dir_rows[$] = '{
        '{-1, 16'h0000, 16'h0000, 1, 16'h0000, 16'h0000},
        '{-1, 16'h7fff, 16'h8000, 1, 16'h7fff, 16'h8000},
        '{-1, 16'h8000, 16'h7fff, 1, 16'h8000, 16'h7fff},
        '{-1, 16'hffff, 16'h0001, 1, 16'hffff, 16'h0001},
        '{-1, 16'h5555, 16'haaaa, 1, 16'h5555, 16'haaaa},
        // first result after a mode write comes from silence: zero
        '{ 1, 16'h0000, 16'h0000, 1, 16'h0000, 16'h0000},
        '{-1, 16'h7fff, 16'h7fff, 0, 16'h0000, 16'h0000},
        '{-1, 16'h7fff, 16'h7fff, 0, 16'h0000, 16'h0000},
        '{-1, 16'h8000, 16'h8000, 0, 16'h0000, 16'h0000},
        '{-1, 16'h7fff, 16'h0000, 0, 16'h0000, 16'h0000},
        '{-1, 16'h0000, 16'h8000, 0, 16'h0000, 16'h0000},
        '{-1, 16'h8000, 16'h7fff, 0, 16'h0000, 16'h0000},
        '{ 2, 16'h0000, 16'h0000, 1, 16'h0000, 16'h0000},
        '{-1, 16'h8000, 16'h8000, 0, 16'h0000, 16'h0000},
        '{-1, 16'h7fff, 16'h8000, 0, 16'h0000, 16'h0000},
        '{-1, 16'h8000, 16'h7fff, 0, 16'h0000, 16'h0000},
        '{-1, 16'h7fff, 16'h7fff, 0, 16'h0000, 16'h0000},
        '{-1, 16'h1234, 16'hedcb, 0, 16'h0000, 16'h0000},
        // unused mode code behaves as bypass
        '{ 3, 16'h8000, 16'h0001, 1, 16'h8000, 16'h0001},
        '{-1, 16'h7ffe, 16'hfffe, 1, 16'h7ffe, 16'hfffe},
        '{ 0, 16'h0001, 16'h8000, 1, 16'h0001, 16'h8000}
    };

    logic [1:0] phase_modes [8] = '{MODE_6M, MODE_8M, MODE_BYPASS, MODE_8M,
                                    2'd3, MODE_6M, MODE_8M, MODE_6M};

    initial begin
        int n;
        logic [15:0] a, b;
        make_tables();
        repeat (8) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].wr_mode >= 0) write_mode(2'(dir_rows[r].wr_mode));
            send_word(dir_rows[r].i, dir_rows[r].q, dir_rows[r].typed,
                      dir_rows[r].ei, dir_rows[r].eq);
        end

        foreach (phase_modes[p]) begin
            write_mode(phase_modes[p]);
            idle_en = (p % 3) != 2;
            n = (phase_modes[p] == MODE_6M || phase_modes[p] == MODE_8M) ? 300 : 100;
            for (int k = 0; k < n; k++) begin
                if (k % 40 < 8) begin
                    // tone burst: slow ramp so the filter passband is exercised
                    a = 16'(k * 700);
                    b = 16'(k * 300 + 9000);
                end else begin
                    a = rand_sample();
                    b = rand_sample();
                end
                send_word(a, b, 1'b0, 16'h0000, 16'h0000);
            end
        end
        idle_en = 1'b1;

        @(negedge clk) s_valid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire

### low_if_mix_decimate.f
rtl/core/lmd_pkg.sv
rtl/core/lmd_cell.sv
rtl/core/lmd_mixer.sv
rtl/core/low_if_mix_decimate.sv
verif/tb_low_if_mix_decimate.sv
